FILE: hw/rtl/pdie_pkg.sv
// Shared types and constants of the pulse-distance IR encoder.
// Holds item structs, register file layout and sequencer step codes; no dependencies.
`default_nettype none
package pdie_pkg;

    localparam int DUR_W = 18;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = DUR_W;
    localparam int STEP_W = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [DUR_W-1:0] HDR_MARK_RST   = DUR_W'(9000);
    localparam logic [DUR_W-1:0] HDR_SPACE_RST  = DUR_W'(4500);
    localparam logic [DUR_W-1:0] BIT_MARK_RST   = DUR_W'(560);
    localparam logic [DUR_W-1:0] ONE_SPACE_RST  = DUR_W'(1690);
    localparam logic [DUR_W-1:0] ZERO_SPACE_RST = DUR_W'(560);
    localparam logic [DUR_W-1:0] GAP_RST        = DUR_W'(20000);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [DUR_W-1:0] duration_us;
        logic             is_mark;
        logic             end_of_run;
    } t_out_item;

    typedef struct packed {
        logic [DUR_W-1:0] header_mark_us;
        logic [DUR_W-1:0] header_space_us;
        logic [DUR_W-1:0] bit_mark_us;
        logic [DUR_W-1:0] one_space_us;
        logic [DUR_W-1:0] zero_space_us;
        logic [DUR_W-1:0] gap_us;
        logic             footer_enable;
        logic             msb_first;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_MARK  = 4'd0,
        CFG_HEADER_SPACE = 4'd1,
        CFG_BIT_MARK     = 4'd2,
        CFG_ONE_SPACE    = 4'd3,
        CFG_ZERO_SPACE   = 4'd4,
        CFG_GAP          = 4'd5,
        CFG_FOOTER_EN    = 4'd6,
        CFG_MSB_FIRST    = 4'd7
    } t_cfg_idx;

    // bits in send order, header, footer and gap flags
    typedef struct packed {
        logic [7:0] bits;
        logic       hdr;
        logic       ftr;
        logic       gap;
    } t_cmd;

    localparam logic [STEP_W-1:0] STEP_HDR_MARK      = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_HDR_SPACE     = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_BIT0_MARK     = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_LAST_BIT_SPACE = STEP_W'(17);
    localparam logic [STEP_W-1:0] STEP_FOOTER        = STEP_W'(18);
    localparam logic [STEP_W-1:0] STEP_GAP           = STEP_W'(19);

endpackage
`default_nettype wire

FILE: hw/rtl/pdie_front.sv
// Front end: accepts bytes, tracks the open frame and builds sequencer commands.
// Depends on pdie_pkg.
`default_nettype none
module pdie_front
    import pdie_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_data,
    input  wire t_cfg     i_cfg,
    output logic          o_push,
    output t_cmd          o_cmd,
    input  wire logic     i_push_ready
);

    logic r_in_frame;
    logic n_in_frame;
    logic [7:0] ordered;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            ordered[k] = i_cfg.msb_first ? i_data.data_byte[7-k] : i_data.data_byte[k];
        end
    end

    assign o_ready = i_push_ready;
    assign o_push  = i_valid && i_push_ready;

    always_comb begin
        o_cmd.bits = ordered;
        o_cmd.hdr  = !r_in_frame;
        o_cmd.ftr  = i_data.last_byte && i_cfg.footer_enable;
        o_cmd.gap  = i_data.last_byte && (i_cfg.gap_us != '0);
        n_in_frame = o_push ? !i_data.last_byte : r_in_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/pdie_queue.sv
// Short command queue between front end and sequencer.
// Depends on pdie_pkg.
`default_nettype none
module pdie_queue
    import pdie_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_push_ready,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_cmd        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/pdie_back.sv
// Back end: steps durations into an output register, one per cycle unless stalled.
// Depends on pdie_pkg.
`default_nettype none
module pdie_back
    import pdie_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out_item o_data
);

    logic              r_mid, n_mid;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_valid, n_valid;
    t_out_item         r_data, n_data;

    logic              advance;
    logic              emit;
    logic [STEP_W-1:0] cur;
    logic [STEP_W-1:0] nxt;
    logic [STEP_W-1:0] bit_pos;
    logic              last;

    assign advance = !r_valid || i_ready;
    assign emit    = advance && i_cmd_valid;
    assign cur     = r_mid ? r_step : (i_cmd.hdr ? STEP_HDR_MARK : STEP_BIT0_MARK);
    assign bit_pos = cur - STEP_BIT0_MARK;

    always_comb begin
        nxt = cur + STEP_W'(1);
        last = 1'b0;
        n_data.is_mark = 1'b0;
        n_data.duration_us = i_cfg.bit_mark_us;
        if (cur == STEP_HDR_MARK) begin
            n_data.duration_us = i_cfg.header_mark_us;
            n_data.is_mark     = 1'b1;
        end else if (cur == STEP_HDR_SPACE) begin
            n_data.duration_us = i_cfg.header_space_us;
        end else if (cur == STEP_FOOTER) begin
            n_data.is_mark = 1'b1;
            last           = !i_cmd.gap;
        end else if (cur == STEP_GAP) begin
            n_data.duration_us = i_cfg.gap_us;
            last               = 1'b1;
        end else if (!bit_pos[0]) begin
            n_data.is_mark = 1'b1;
        end else begin
            n_data.duration_us = i_cmd.bits[bit_pos[3:1]] ? i_cfg.one_space_us
                                                          : i_cfg.zero_space_us;
            if (cur == STEP_LAST_BIT_SPACE) begin
                last = !i_cmd.ftr && !i_cmd.gap;
                nxt  = i_cmd.ftr ? STEP_FOOTER : STEP_GAP;
            end
        end
        n_data.end_of_run = last;

        o_pop   = emit && last;
        n_mid   = r_mid;
        n_step  = r_step;
        n_valid = r_valid;
        if (advance) begin
            n_valid = i_cmd_valid;
        end
        if (emit) begin
            n_mid  = !last;
            n_step = nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_step  <= STEP_HDR_MARK;
            r_valid <= 1'b0;
        end else begin
            r_mid   <= n_mid;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

FILE: hw/rtl/pulse_distance_ir_encoder.sv
// Pulse-distance IR encoder: frame bytes in, mark/space durations out.
// Holds the register file; depends on pdie_pkg, pdie_front, pdie_queue, pdie_back.
//
// Input channel (i_valid/o_ready, i_data): one frame byte per item with its
// last-byte flag. Output channel (o_valid/i_ready, o_data): one duration per
// item, is_mark for carrier on, end_of_run on the last duration of each byte.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data):
// always ready; unknown indexes are dropped; write only while idle.
// Each byte yields 16 to 20 durations, one per cycle from the sequencer while
// the receiver does not stall; header adds 2, footer and gap 1 each. The
// first duration passes through the command queue, then the output register.
// A command queue of QUEUE_DEPTH entries lets the next bytes enter while one
// is being sent. Reset clears the queue, the output valid flag and the
// open-frame flag, and loads the default timing registers. When the receiver
// stalls, the output register holds and the sequencer waits; bytes keep
// entering until the queue fills.
`default_nettype none
module pulse_distance_ir_encoder
    import pdie_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in_item              i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out_item                  o_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic push, push_ready, pop, cmd_valid;
    t_cmd push_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mark_us  <= HDR_MARK_RST;
            r_cfg.header_space_us <= HDR_SPACE_RST;
            r_cfg.bit_mark_us     <= BIT_MARK_RST;
            r_cfg.one_space_us    <= ONE_SPACE_RST;
            r_cfg.zero_space_us   <= ZERO_SPACE_RST;
            r_cfg.gap_us          <= GAP_RST;
            r_cfg.footer_enable   <= 1'b1;
            r_cfg.msb_first       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEADER_MARK:  r_cfg.header_mark_us  <= i_cfg_data[DUR_W-1:0];
                CFG_HEADER_SPACE: r_cfg.header_space_us <= i_cfg_data[DUR_W-1:0];
                CFG_BIT_MARK:     r_cfg.bit_mark_us     <= i_cfg_data[DUR_W-1:0];
                CFG_ONE_SPACE:    r_cfg.one_space_us    <= i_cfg_data[DUR_W-1:0];
                CFG_ZERO_SPACE:   r_cfg.zero_space_us   <= i_cfg_data[DUR_W-1:0];
                CFG_GAP:          r_cfg.gap_us          <= i_cfg_data[DUR_W-1:0];
                CFG_FOOTER_EN:    r_cfg.footer_enable   <= i_cfg_data[0];
                CFG_MSB_FIRST:    r_cfg.msb_first       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pdie_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .i_cfg        (r_cfg),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_push_ready (push_ready)
    );

    pdie_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_valid      (cmd_valid),
        .o_cmd        (head_cmd)
    );

    pdie_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire

FILE: tb/ir_duration_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the pulse-distance IR encoder: watches the byte, duration and register
// channels, predicts every duration item in order and compares field by field.
// Depends on pdie_pkg.
module ir_duration_checker
    import pdie_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_byte_valid,
    input  wire logic                  i_byte_ready,
    input  wire t_in_item              i_byte,
    input  wire logic                  i_dur_valid,
    input  wire logic                  i_dur_ready,
    input  wire t_out_item             i_dur,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_mismatch_count,
    output int                         o_pending
);

    t_cfg      timing;
    logic      frame_open;
    t_out_item expected_durations[$];
    int        mismatches;

    function automatic void add_duration(input logic [DUR_W-1:0] dur, input logic mark);
        expected_durations.push_back(t_out_item'{duration_us: dur, is_mark: mark,
                                                 end_of_run: 1'b0});
    endfunction

    function automatic void encode_byte(input t_in_item item);
        t_out_item last_dur;
        int pos;
        if (!frame_open) begin
            add_duration(timing.header_mark_us, 1'b1);
            add_duration(timing.header_space_us, 1'b0);
        end
        for (int i = 0; i < 8; i++) begin
            pos = timing.msb_first ? 7 - i : i;
            add_duration(timing.bit_mark_us, 1'b1);
            add_duration(item.data_byte[pos] ? timing.one_space_us : timing.zero_space_us,
                         1'b0);
        end
        if (item.last_byte) begin
            if (timing.footer_enable)
                add_duration(timing.bit_mark_us, 1'b1);
            if (timing.gap_us != '0)
                add_duration(timing.gap_us, 1'b0);
        end
        frame_open = !item.last_byte;
        // flag the final duration of this byte
        last_dur = expected_durations.pop_back();
        last_dur.end_of_run = 1'b1;
        expected_durations.push_back(last_dur);
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] value);
        case (index)
            CFG_HEADER_MARK:  timing.header_mark_us = value;
            CFG_HEADER_SPACE: timing.header_space_us = value;
            CFG_BIT_MARK:     timing.bit_mark_us = value;
            CFG_ONE_SPACE:    timing.one_space_us = value;
            CFG_ZERO_SPACE:   timing.zero_space_us = value;
            CFG_GAP:          timing.gap_us = value;
            CFG_FOOTER_EN:    timing.footer_enable = value[0];
            CFG_MSB_FIRST:    timing.msb_first = value[0];
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            timing = t_cfg'{HDR_MARK_RST, HDR_SPACE_RST, BIT_MARK_RST, ONE_SPACE_RST,
                            ZERO_SPACE_RST, GAP_RST, 1'b1, 1'b0};
            frame_open = 1'b0;
            expected_durations.delete();
            mismatches = 0;
        end else begin
            if (i_dur_valid && i_dur_ready) begin
                if (expected_durations.size() == 0) begin
                    $error("unexpected item: duration_us %0d is_mark %0b end_of_run %0b",
                           i_dur.duration_us, i_dur.is_mark, i_dur.end_of_run);
                    mismatches++;
                end else begin
                    want = expected_durations.pop_front();
                    if (i_dur.duration_us !== want.duration_us) begin
                        $error("duration_us: expected %0d, got %0d",
                               want.duration_us, i_dur.duration_us);
                        mismatches++;
                    end
                    if (i_dur.is_mark !== want.is_mark) begin
                        $error("is_mark: expected %0b, got %0b", want.is_mark, i_dur.is_mark);
                        mismatches++;
                    end
                    if (i_dur.end_of_run !== want.end_of_run) begin
                        $error("end_of_run: expected %0b, got %0b",
                               want.end_of_run, i_dur.end_of_run);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_byte_valid && i_byte_ready)
                encode_byte(i_byte);
        end
        o_mismatch_count <= mismatches;
        o_pending <= expected_durations.size();
    end

endmodule

FILE: tb/pulse_distance_ir_encoder_test.sv
`timescale 1ns / 100ps
// Testbench top for the pulse-distance IR encoder: clock, reset, byte and register
// stimulus, random idling on both channels, watchdog and verdict.
// Depends on pdie_pkg, pulse_distance_ir_encoder and ir_duration_checker.
module pulse_distance_ir_encoder_test;
    import pdie_pkg::*;

    localparam int PHASE_BYTES = 31;
    localparam int RANDOM_PHASES = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;
    localparam int IDX_LIMIT = (1 << CFG_IDX_W) - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_in_item              i_data = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out_item             o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    mismatch_count;
    int                    pending_durations;
    int                    sender_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    quiet_cycles = 0;

    pulse_distance_ir_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ir_duration_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte_valid     (i_valid),
        .i_byte_ready     (o_ready),
        .i_byte           (i_data),
        .i_dur_valid      (o_valid),
        .i_dur_ready      (i_ready),
        .i_dur            (o_data),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_durations)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [DUR_W-1:0] rand_duration();
        case ($urandom_range(3))
            0: return '0;
            1: return DUR_MAX;
            2: return DUR_W'($urandom_range(20000));
            default: return DUR_W'($urandom);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= t_in_item'{data_byte: data, last_byte: last};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // hold bytes until every predicted duration has come out
    task automatic drain(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_durations != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic program_random_timing();
        write_reg(CFG_HEADER_MARK, rand_duration());
        write_reg(CFG_HEADER_SPACE, rand_duration());
        write_reg(CFG_BIT_MARK, rand_duration());
        write_reg(CFG_ONE_SPACE, rand_duration());
        write_reg(CFG_ZERO_SPACE, rand_duration());
        write_reg(CFG_GAP, rand_duration());
        write_reg(CFG_FOOTER_EN, CFG_DATA_W'($urandom));
        write_reg(CFG_MSB_FIRST, CFG_DATA_W'($urandom));
        if ($urandom_range(2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(IDX_LIMIT, int'(CFG_MSB_FIRST) + 1)),
                      CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_phase();
        int sent;
        int len;
        sent = 0;
        while (sent < PHASE_BYTES) begin
            len = $urandom_range(1, 5);
            // mostly whole frames, some with a stray or missing last flag
            for (int k = 0; k < len; k++)
                push_byte(8'($urandom),
                          ($urandom_range(7) == 0) ? 1'($urandom) : 1'(k == len - 1));
            sent += len;
            if ($urandom_range(9) == 0)
                drain(0);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b1);
        push_byte(8'h01, 1'b0);
        drain(0);
        // change timing inside an open frame
        write_reg(CFG_BIT_MARK, DUR_MAX);
        i_cfg_valid <= 1'b0;
        push_byte(8'h80, 1'b1);
        drain(0);

        write_reg(CFG_HEADER_MARK, '0);
        write_reg(CFG_HEADER_SPACE, '0);
        write_reg(CFG_BIT_MARK, '0);
        write_reg(CFG_ONE_SPACE, '0);
        write_reg(CFG_ZERO_SPACE, '0);
        write_reg(CFG_GAP, '0);
        write_reg(CFG_FOOTER_EN, DUR_MAX - 1'b1);
        write_reg(CFG_MSB_FIRST, DUR_MAX);
        write_reg(CFG_IDX_W'(int'(CFG_MSB_FIRST) + 1), DUR_MAX);
        write_reg(CFG_IDX_W'(IDX_LIMIT), '0);
        i_cfg_valid <= 1'b0;
        push_byte(8'h01, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'hC3, 1'b1);
        drain(0);

        write_reg(CFG_HEADER_MARK, DUR_MAX);
        write_reg(CFG_HEADER_SPACE, DUR_MAX);
        write_reg(CFG_BIT_MARK, DUR_MAX);
        write_reg(CFG_ONE_SPACE, DUR_MAX);
        write_reg(CFG_ZERO_SPACE, DUR_MAX);
        write_reg(CFG_GAP, DUR_MAX);
        write_reg(CFG_FOOTER_EN, CFG_DATA_W'(3));
        write_reg(CFG_MSB_FIRST, CFG_DATA_W'(2));
        i_cfg_valid <= 1'b0;
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h96, 1'b0);
        push_byte(8'h69, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain(0);
            program_random_timing();
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default: begin
                    sender_idle_pct = 19;
                    recv_stall_pct = 19;
                end
            endcase
            send_random_phase();
        end

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/pdie_pkg.sv
hw/rtl/pdie_front.sv
hw/rtl/pdie_queue.sv
hw/rtl/pdie_back.sv
hw/rtl/pulse_distance_ir_encoder.sv
tb/ir_duration_checker.sv
tb/pulse_distance_ir_encoder_test.sv
